### rtl/tkw_pkg.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper package
// Shared widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package tkw_pkg;

   localparam int KEEP_W      = 5;
   localparam int WEIGHT_W    = 32;
   localparam int TAG_W       = 16;
   localparam int POS_W       = 4;
   localparam int MAX_RESULTS = 16;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_PUSH_START = 7'b0000010,
      ST_PUSH_SCAN  = 7'b0000100,
      ST_PUSH_END   = 7'b0001000,
      ST_LIST_RD    = 7'b0010000,
      ST_LIST_LOAD  = 7'b0100000,
      ST_RSP        = 7'b1000000
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_next;
      logic scan;
      logic push_end;
      logic out_zero;
      logic list_load;
      logic list_next;
   } tkw_cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic scan_done;
      logic out_last;
   } tkw_sts_type;

endpackage

### rtl/top_k_weight_keeper.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper
// Keeps the best entries by signed weight in a descending list.
// ----------------------------------------------------------------------------
// The req channel takes one beat per operation: op 0 pushes req_tag with
// req_weight, op 1 reads the list. A push gives one rsp beat telling whether
// and where the entry landed and which entry, if any, fell off the end. A
// read gives one beat per stored entry from rank 0, at most sixteen, with
// rsp_last on the final one; an empty list gives one zero beat with rsp_last.
// The csr channel writes the keep count; it is always ready and is to be
// written only while no operation is in flight.
// A push runs a scan that reads each stored entry once from the entry RAM
// and shifts the tail through a carry register. Each read beat is read from
// the RAM, loaded into the result register and then presented. One
// operation is in flight at a time: req_ready is high only when the
// previous operation's last beat has been taken.
// A stalled rsp beat is held in the result register until it is taken.
// Reset empties the list and sets the keep count to sixteen; entry storage
// needs no clearing since only the contents of filled slots are ever used.
// ----------------------------------------------------------------------------
module top_k_weight_keeper #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [tkw_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [tkw_pkg::TAG_W-1:0]           req_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kept,
   output logic [tkw_pkg::POS_W-1:0]           rsp_position,
   output logic                                rsp_evicted,
   output logic [tkw_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic signed [tkw_pkg::WEIGHT_W-1:0] rsp_out_weight,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tkw_pkg::KEEP_W-1:0]          csr_data
);

   tkw_pkg::tkw_cmd_type cmd;
   tkw_pkg::tkw_sts_type sts;

   assign csr_ready = 1'b1;

   tkw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tkw_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_weight     (req_weight),
      .req_tag        (req_tag),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_kept       (rsp_kept),
      .rsp_position   (rsp_position),
      .rsp_evicted    (rsp_evicted),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_weight (rsp_out_weight),
      .rsp_last       (rsp_last)
   );

endmodule

### rtl/tkw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tkw_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/tkw_datapath.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper datapath
// Entry store, fill and keep registers, insertion scan and result register.
// ----------------------------------------------------------------------------
module tkw_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tkw_pkg::tkw_cmd_type                 cmd,
   output tkw_pkg::tkw_sts_type                 sts,
   input  logic signed [tkw_pkg::WEIGHT_W-1:0]  req_weight,
   input  logic [tkw_pkg::TAG_W-1:0]            req_tag,
   input  logic                                 csr_valid,
   input  logic [tkw_pkg::KEEP_W-1:0]           csr_data,
   output logic                                 rsp_kept,
   output logic [tkw_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_evicted,
   output logic [tkw_pkg::TAG_W-1:0]            rsp_out_tag,
   output logic signed [tkw_pkg::WEIGHT_W-1:0]  rsp_out_weight,
   output logic                                 rsp_last
);

   localparam int IW   = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int FW   = $clog2(CAPACITY + 1);
   localparam int CMPW = FW > tkw_pkg::KEEP_W ? FW : tkw_pkg::KEEP_W;
   localparam int EW   = tkw_pkg::WEIGHT_W + tkw_pkg::TAG_W;

   logic [FW-1:0]                     fill_ff, fill_in;
   logic [tkw_pkg::KEEP_W-1:0]        keep_ff, keep_in;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic signed [tkw_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [tkw_pkg::TAG_W-1:0]         tag_ff, tag_in;
   logic                              inserted_ff, inserted_in;
   logic [IW-1:0]                     pos_ff, pos_in;
   logic [EW-1:0]                     carry_ff, carry_in;
   logic                              kept_ff, kept_in;
   logic [tkw_pkg::POS_W-1:0]         position_ff, position_in;
   logic                              evicted_ff, evicted_in;
   logic [tkw_pkg::TAG_W-1:0]         out_tag_ff, out_tag_in;
   logic signed [tkw_pkg::WEIGHT_W-1:0] out_weight_ff, out_weight_in;
   logic                              last_ff, last_in;

   logic [FW-1:0]                     eff_keep;
   logic [FW-1:0]                     new_eff_keep;
   logic [FW-1:0]                     fill_last;
   logic                              scan_done;
   logic                              list_done;
   logic                              greater;
   logic signed [tkw_pkg::WEIGHT_W-1:0] rd_weight;
   logic [tkw_pkg::TAG_W-1:0]         rd_tag;
   logic [EW-1:0]                     rd_data;
   logic [IW-1:0]                     rd_addr;
   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic [EW-1:0]                     wr_data;

   tkw_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A keep count above the capacity acts as the capacity.
   always_comb begin
      if (CMPW'(keep_ff) > CMPW'(CAPACITY)) begin
         eff_keep = FW'(CAPACITY);
      end else begin
         eff_keep = FW'(keep_ff);
      end
      if (CMPW'(csr_data) > CMPW'(CAPACITY)) begin
         new_eff_keep = FW'(CAPACITY);
      end else begin
         new_eff_keep = FW'(csr_data);
      end
   end

   assign rd_weight = rd_data[EW-1:tkw_pkg::TAG_W];
   assign rd_tag    = rd_data[tkw_pkg::TAG_W-1:0];
   assign greater   = weight_ff > rd_weight;
   assign fill_last = fill_ff - FW'(1);
   assign scan_done = FW'(idx_ff) == fill_last;
   assign rd_addr   = cmd.rd_next ? idx_ff + IW'(1) : idx_ff;

   // A read streams at most MAX_RESULTS entries.
   always_comb begin
      if (CMPW'(fill_ff) > CMPW'(tkw_pkg::MAX_RESULTS)) begin
         list_done = CMPW'(idx_ff) == CMPW'(tkw_pkg::MAX_RESULTS - 1);
      end else begin
         list_done = FW'(idx_ff) == fill_last;
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      keep_in       = keep_ff;
      idx_in        = idx_ff;
      weight_in     = weight_ff;
      tag_in        = tag_ff;
      inserted_in   = inserted_ff;
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      kept_in       = kept_ff;
      position_in   = position_ff;
      evicted_in    = evicted_ff;
      out_tag_in    = out_tag_ff;
      out_weight_in = out_weight_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {weight_ff, tag_ff};

      // Lowering the keep count drops trailing entries without a report.
      if (csr_valid) begin
         keep_in = csr_data;
         if (fill_ff > new_eff_keep) begin
            fill_in = new_eff_keep;
         end
      end

      if (cmd.accept) begin
         weight_in   = req_weight;
         tag_in      = req_tag;
         idx_in      = '0;
         inserted_in = 1'b0;
      end

      // Once the new entry is placed, every later entry moves down one slot
      // through the carry register.
      if (cmd.scan) begin
         idx_in = idx_ff + IW'(1);
         if (inserted_ff) begin
            wr_en    = 1'b1;
            wr_data  = carry_ff;
            carry_in = rd_data;
         end else if (greater) begin
            wr_en       = 1'b1;
            carry_in    = rd_data;
            inserted_in = 1'b1;
            pos_in      = idx_ff;
         end
      end

      if (cmd.push_end) begin
         kept_in       = 1'b0;
         position_in   = '0;
         evicted_in    = 1'b0;
         out_tag_in    = '0;
         out_weight_in = '0;
         last_in       = 1'b1;
         if (inserted_ff) begin
            kept_in     = 1'b1;
            position_in = tkw_pkg::POS_W'(pos_ff);
            if (fill_ff == eff_keep) begin
               evicted_in    = 1'b1;
               out_tag_in    = carry_ff[tkw_pkg::TAG_W-1:0];
               out_weight_in = carry_ff[EW-1:tkw_pkg::TAG_W];
            end else begin
               wr_en   = 1'b1;
               wr_addr = fill_ff[IW-1:0];
               wr_data = carry_ff;
               fill_in = fill_ff + FW'(1);
            end
         end else if (fill_ff < eff_keep) begin
            wr_en       = 1'b1;
            wr_addr     = fill_ff[IW-1:0];
            kept_in     = 1'b1;
            position_in = tkw_pkg::POS_W'(fill_ff);
            fill_in     = fill_ff + FW'(1);
         end
      end

      if (cmd.out_zero) begin
         kept_in       = 1'b0;
         position_in   = '0;
         evicted_in    = 1'b0;
         out_tag_in    = '0;
         out_weight_in = '0;
         last_in       = 1'b1;
      end

      if (cmd.list_load) begin
         kept_in       = 1'b1;
         position_in   = tkw_pkg::POS_W'(idx_ff);
         evicted_in    = 1'b0;
         out_tag_in    = rd_tag;
         out_weight_in = rd_weight;
         last_in       = list_done;
      end

      if (cmd.list_next) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         keep_ff <= tkw_pkg::KEEP_RESET;
      end else begin
         fill_ff <= fill_in;
         keep_ff <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      weight_ff     <= weight_in;
      tag_ff        <= tag_in;
      inserted_ff   <= inserted_in;
      pos_ff        <= pos_in;
      carry_ff      <= carry_in;
      kept_ff       <= kept_in;
      position_ff   <= position_in;
      evicted_ff    <= evicted_in;
      out_tag_ff    <= out_tag_in;
      out_weight_ff <= out_weight_in;
      last_ff       <= last_in;
   end

   assign sts.fill_zero = fill_ff == '0;
   assign sts.scan_done = scan_done;
   assign sts.out_last  = last_ff;

   assign rsp_kept       = kept_ff;
   assign rsp_position   = position_ff;
   assign rsp_evicted    = evicted_ff;
   assign rsp_out_tag    = out_tag_ff;
   assign rsp_out_weight = out_weight_ff;
   assign rsp_last       = last_ff;

endmodule

### rtl/tkw_controller.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper controller
// Sequences the insertion scan, the list read-out and the result handshake.
// ----------------------------------------------------------------------------
module tkw_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tkw_pkg::tkw_cmd_type cmd,
   input  tkw_pkg::tkw_sts_type sts
);

   tkw_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         tkw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == tkw_pkg::OP_READ) begin
                  if (sts.fill_zero) begin
                     cmd.out_zero = 1'b1;
                     state_in     = tkw_pkg::ST_RSP;
                  end else begin
                     state_in = tkw_pkg::ST_LIST_RD;
                  end
               end else begin
                  state_in = tkw_pkg::ST_PUSH_START;
               end
            end
         end
         tkw_pkg::ST_PUSH_START: begin
            // The first entry is read here so the scan sees it next cycle.
            if (sts.fill_zero) begin
               state_in = tkw_pkg::ST_PUSH_END;
            end else begin
               state_in = tkw_pkg::ST_PUSH_SCAN;
            end
         end
         tkw_pkg::ST_PUSH_SCAN: begin
            cmd.scan    = 1'b1;
            cmd.rd_next = 1'b1;
            if (sts.scan_done) begin
               state_in = tkw_pkg::ST_PUSH_END;
            end
         end
         tkw_pkg::ST_PUSH_END: begin
            cmd.push_end = 1'b1;
            state_in     = tkw_pkg::ST_RSP;
         end
         tkw_pkg::ST_LIST_RD: begin
            state_in = tkw_pkg::ST_LIST_LOAD;
         end
         tkw_pkg::ST_LIST_LOAD: begin
            cmd.list_load = 1'b1;
            state_in      = tkw_pkg::ST_RSP;
         end
         tkw_pkg::ST_RSP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.out_last) begin
                  state_in = tkw_pkg::ST_IDLE;
               end else begin
                  cmd.list_next = 1'b1;
                  state_in      = tkw_pkg::ST_LIST_RD;
               end
            end
         end
         default: begin
            state_in = tkw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/tkw_checker.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tkw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_kept,
   input logic                                rsp_evicted,
   input logic                                rsp_last,
   input logic signed [tkw_pkg::WEIGHT_W-1:0] rsp_out_weight
);

   // A stalled beat stays valid and keeps its weight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_weight))
      else $error("rsp beat changed while stalled");

   // Only one operation is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat could be taken right after acceptance");

   // An eviction only comes with a push that landed, which ends its operation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_kept && rsp_last)
      else $error("eviction reported without a kept entry");

   // More read beats follow a beat without last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("new request taken before the read-out finished");

endmodule

bind top_k_weight_keeper tkw_checker u_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Top-k weight keeper testbench
// Drives push and read requests into the keeper with bursty traffic and a
// stalling receiver. A shadow copy of the ranked list predicts every result
// beat, and each beat is checked field by field. The keep count is changed
// between phases, including zero, one, full capacity and oversized values.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CAPACITY      = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 40;

   localparam logic signed [tkw_pkg::WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [tkw_pkg::WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                                kept;
      logic [tkw_pkg::POS_W-1:0]           position;
      logic                                evicted;
      logic [tkw_pkg::TAG_W-1:0]           out_tag;
      logic signed [tkw_pkg::WEIGHT_W-1:0] out_weight;
      logic                                last;
   } result_beat_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef enum logic [1:0] {
      WEIGHT_ANY,
      WEIGHT_NEAR_ZERO,
      WEIGHT_EXTREME
   } weight_style_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_op = tkw_pkg::OP_PUSH;
   logic signed [tkw_pkg::WEIGHT_W-1:0] req_weight = '0;
   logic [tkw_pkg::TAG_W-1:0]           req_tag = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_kept;
   logic [tkw_pkg::POS_W-1:0]           rsp_position;
   logic                                rsp_evicted;
   logic [tkw_pkg::TAG_W-1:0]           rsp_out_tag;
   logic signed [tkw_pkg::WEIGHT_W-1:0] rsp_out_weight;
   logic                                rsp_last;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [tkw_pkg::KEEP_W-1:0]          csr_data = '0;

   // Shadow of the ranked list and the keep count.
   logic signed [tkw_pkg::WEIGHT_W-1:0] ranked_weight [CAPACITY];
   logic [tkw_pkg::TAG_W-1:0]           ranked_tag [CAPACITY];
   int                                  ranked_fill = 0;
   logic [tkw_pkg::KEEP_W-1:0]          keep_setting = tkw_pkg::KEEP_RESET;

   result_beat_type pending_results [$];
   result_beat_type want_beat;

   int             cycle_count = 0;
   int             error_count = 0;
   int             burst_left = 0;
   int             push_count = 0;
   int             read_count = 0;
   int             beat_count = 0;
   int             evict_count = 0;
   int             drop_count = 0;
   int             keep_writes = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;

   top_k_weight_keeper #(.CAPACITY(CAPACITY)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_weight     (req_weight),
      .req_tag        (req_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kept       (rsp_kept),
      .rsp_position   (rsp_position),
      .rsp_evicted    (rsp_evicted),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_weight (rsp_out_weight),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver switches at random between stall patterns.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(20, 120);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_ready <= 1'b1;
         STALL_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= ((cycle_count % 7) < 3);
      endcase
   end

   function automatic int effective_keep();
      return (keep_setting > CAPACITY) ? CAPACITY : int'(keep_setting);
   endfunction

   function automatic void queue_beat(input result_beat_type beat);
      pending_results = {pending_results, beat};
   endfunction

   function automatic void rank_push(input logic signed [tkw_pkg::WEIGHT_W-1:0] weight,
                                     input logic [tkw_pkg::TAG_W-1:0] tag);
      result_beat_type beat;
      int              limit;
      int              slot;
      beat = '0;
      beat.last = 1'b1;
      limit = effective_keep();
      if (limit == 0) begin
         drop_count++;
      end else begin
         if (ranked_fill > limit)
            ranked_fill = limit;
         // Equal weights do not displace, so a tie lands behind the old entry.
         slot = 0;
         while (slot < ranked_fill && !(weight > ranked_weight[slot]))
            slot++;
         if (slot < ranked_fill || ranked_fill < limit) begin
            if (slot < ranked_fill && ranked_fill == limit) begin
               beat.evicted    = 1'b1;
               beat.out_tag    = ranked_tag[ranked_fill-1];
               beat.out_weight = ranked_weight[ranked_fill-1];
               ranked_fill--;
               evict_count++;
            end
            for (int j = ranked_fill; j > slot; j--) begin
               ranked_weight[j] = ranked_weight[j-1];
               ranked_tag[j]    = ranked_tag[j-1];
            end
            ranked_weight[slot] = weight;
            ranked_tag[slot]    = tag;
            ranked_fill++;
            beat.kept     = 1'b1;
            beat.position = slot[tkw_pkg::POS_W-1:0];
         end else begin
            drop_count++;
         end
      end
      queue_beat(beat);
   endfunction

   function automatic void rank_readout();
      result_beat_type beat;
      int              count;
      count = (ranked_fill > tkw_pkg::MAX_RESULTS) ? tkw_pkg::MAX_RESULTS : ranked_fill;
      if (count == 0) begin
         beat = '0;
         beat.last = 1'b1;
         queue_beat(beat);
      end
      for (int i = 0; i < count; i++) begin
         beat = '0;
         beat.kept       = 1'b1;
         beat.position   = i[tkw_pkg::POS_W-1:0];
         beat.out_tag    = ranked_tag[i];
         beat.out_weight = ranked_weight[i];
         beat.last       = (i == count - 1);
         queue_beat(beat);
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("rsp_%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beat_count++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected (tag 0x%0h)", rsp_out_tag);
            error_count++;
         end else begin
            want_beat = pending_results.pop_front();
            check_field("kept", want_beat.kept, rsp_kept);
            check_field("position", want_beat.position, rsp_position);
            check_field("evicted", want_beat.evicted, rsp_evicted);
            check_field("out_tag", want_beat.out_tag, rsp_out_tag);
            check_field("out_weight", want_beat.out_weight, rsp_out_weight);
            check_field("last", want_beat.last, rsp_last);
         end
      end
   end

   // Sends one request beat. Valid is left high on return so that a
   // back-to-back request does not drop it in between.
   task automatic send_request(input logic op,
                               input logic signed [tkw_pkg::WEIGHT_W-1:0] weight,
                               input logic [tkw_pkg::TAG_W-1:0] tag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_weight <= weight;
      req_tag    <= tag;
      do @(posedge clock); while (!req_ready);
      if (op == tkw_pkg::OP_READ) begin
         rank_readout();
         read_count++;
      end else begin
         rank_push(weight, tag);
         push_count++;
      end
   endtask

   task automatic push(input logic signed [tkw_pkg::WEIGHT_W-1:0] weight,
                       input logic [tkw_pkg::TAG_W-1:0] tag);
      send_request(tkw_pkg::OP_PUSH, weight, tag);
   endtask

   task automatic read_list();
      send_request(tkw_pkg::OP_READ, $urandom, tkw_pkg::TAG_W'($urandom_range(0, 65535)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input logic [tkw_pkg::KEEP_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      keep_setting = value;
      // Lowering the count trims the tail without any report.
      if (ranked_fill > effective_keep())
         ranked_fill = effective_keep();
      keep_writes++;
   endtask

   task automatic test_extremes_and_ties();
      read_list();
      push(WEIGHT_MAX, 16'hFFFF);
      push(WEIGHT_MIN, 16'h0000);
      push(32'sd0, 16'h1234);
      push(32'sd0, 16'hEDCB);
      push(-32'sd1, 16'h5A5A);
      read_list();
   endtask

   task automatic test_eviction_and_drop();
      write_keep(5'd3);
      read_list();
      push(32'sd1, 16'hA5A5);
      push(WEIGHT_MIN, 16'h0F0F);
      push(32'sd0, 16'hF0F0);
      read_list();
   endtask

   task automatic test_disabled_and_oversized();
      write_keep(5'd0);
      push(WEIGHT_MAX, 16'h8001);
      read_list();
      write_keep(5'd31);
      push(WEIGHT_MIN, 16'h7FFE);
      push(WEIGHT_MIN, 16'h4242);
      read_list();
   endtask

   function automatic logic signed [tkw_pkg::WEIGHT_W-1:0] pick_weight(
         input weight_style_type style);
      case (style)
         WEIGHT_NEAR_ZERO: return $signed($urandom_range(0, 7)) - 4;
         WEIGHT_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return WEIGHT_MAX;
               1:       return WEIGHT_MIN;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_phases();
      logic [tkw_pkg::KEEP_W-1:0] keep_plan [12];
      weight_style_type           style;
      keep_plan = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd0, 5'd8,
                    5'd17, 5'd15, 5'd5, 5'd16, 5'd4, 5'd0};
      keep_plan[10] = tkw_pkg::KEEP_W'($urandom_range(1, 31));
      foreach (keep_plan[p]) begin
         write_keep(keep_plan[p]);
         style = weight_style_type'($urandom_range(0, 2));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 49) == 0)
               wait_idle();
            if ($urandom_range(0, 9) < 2) begin
               read_list();
            end else begin
               if ($urandom_range(0, 4) == 0)
                  style = weight_style_type'($urandom_range(0, 2));
               push(pick_weight(style), tkw_pkg::TAG_W'($urandom_range(0, 65535)));
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes_and_ties();
      test_eviction_and_drop();
      test_disabled_and_oversized();
      test_random_phases();
      wait_idle();

      $display("Sent %0d pushes and %0d reads across %0d keep-count writes.",
               push_count, read_count, keep_writes);
      $display("Checked %0d result beats, with %0d evictions and %0d dropped pushes.",
               beat_count, evict_count, drop_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/tkw_pkg.sv
rtl/tkw_ram.sv
rtl/tkw_datapath.sv
rtl/tkw_controller.sv
rtl/top_k_weight_keeper.sv
rtl/tkw_checker.sv
tb/tb_top.sv
